### sv/table_interp_and_inverse_lookup_defines.svh
`ifndef TABLE_INTERP_AND_INVERSE_LOOKUP_DEFINES_SVH
`define TABLE_INTERP_AND_INVERSE_LOOKUP_DEFINES_SVH

// same-cycle implication
`define TII_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TII_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/tii_pkg.sv
`timescale 1ns / 1ps

package tii_pkg;
   localparam int TABLE_DEPTH   = 256;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = IDX_W + 1;
   localparam int FRAC_W        = 16;
   localparam int QPOS_W        = IDX_W + FRAC_W;
   localparam int FPOS_W        = QPOS_W + 1;
   localparam int VAL_W         = 32;
   localparam int TINY_LIM      = ((1 << FRAC_W) + 99999) / 100000;
   localparam int DIV_CNT_W     = $clog2(FRAC_W + 1);

   typedef enum logic [1:0] {
      MODE_WR  = 2'd0,
      MODE_FWD = 2'd1,
      MODE_INV = 2'd2,
      MODE_NOP = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_BELOW = 2'd1,
      ST_END   = 2'd2,
      ST_FLAT  = 2'd3
   } status_type;
endpackage

### sv/table_interp_and_inverse_lookup.sv
`timescale 1ns / 1ps

// channel | ports                     | moves
// req     | req_valid / req_ready     | table write, forward query or inverse query
// rsp     | rsp_valid / rsp_ready     | one result per forward or inverse query
// csr     | csr_valid / csr_ready     | entries_in_use
//
// one item at a time: a new request is taken only once the previous table write,
// forward query or inverse query is done; query time is set by the single read port
// of the table memory and, for an inverse query, by the bit-serial divider
// reset is synchronous and clears control only; the table holds garbage until written
// a result waits in the output register; a held result stalls the next completion

module table_interp_and_inverse_lookup (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_mode,
   input  logic [7:0]                         req_entry_index,
   input  logic signed [31:0]                 req_entry_value,
   input  logic [23:0]                        req_query_position,
   input  logic signed [31:0]                 req_probe_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [31:0]                 rsp_interp_value,
   output logic [24:0]                        rsp_found_position,
   output logic [1:0]                         rsp_status,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [8:0]                         csr_entries_in_use
);
   localparam int IW = tii_pkg::IDX_W;
   localparam int FW = tii_pkg::FRAC_W;
   localparam int VW = tii_pkg::VAL_W;

   typedef enum logic [3:0] {
      S_IDLE, S_F_A, S_F_B, S_F_C, S_F_D,
      S_I_A, S_I_B, S_I_C, S_I_S, S_I_W, S_I_M, S_I_D, S_I_V, S_DONE
   } state_type;

   state_type                      state_ff;
   logic [tii_pkg::CNT_W-1:0]      entries_ff;
   logic [VW-1:0]                  mem [tii_pkg::TABLE_DEPTH];
   logic [IW-1:0]                  raddr_ff;
   logic signed [VW-1:0]           rdata_ff;

   logic                           single_ff;
   logic [FW-1:0]                  frac_ff;
   logic [IW-1:0]                  ip1_ff;
   logic signed [VW-1:0]           a_ff;
   logic signed [VW+FW+1:0]        pa_ff;
   logic signed [VW+FW+1:0]        pb_ff;
   logic signed [VW-1:0]           x_ff;
   logic signed [VW-1:0]           lo_v_ff;
   logic signed [VW-1:0]           up_v_ff;
   logic [IW-1:0]                  low_ff;
   logic [IW-1:0]                  up_ff;
   logic [IW-1:0]                  mid_ff;

   logic signed [VW-1:0]           res_val_ff;
   logic [tii_pkg::FPOS_W-1:0]     res_pos_ff;
   tii_pkg::status_type            res_st_ff;
   logic                           rsp_valid_ff;
   logic signed [VW-1:0]           rsp_val_ff;
   logic [tii_pkg::FPOS_W-1:0]     rsp_pos_ff;
   logic [1:0]                     rsp_st_ff;

   logic [tii_pkg::CNT_W-1:0]      n_act;
   logic [IW-1:0]                  last_idx;
   logic                           req_xfer;
   logic [IW-1:0]                  q_ip;
   logic [FW-1:0]                  q_f;
   logic                           q_tiny;
   logic                           q_end;
   logic signed [VW+FW+2:0]        sum;
   logic signed [VW+FW+2:0]        rnd;
   logic signed [VW:0]             den;
   logic signed [VW:0]             num_raw;
   logic [VW:0]                    num_clamp;
   logic [IW:0]                    mid_sum;
   logic                           div_start;
   logic                           div_done;
   logic [FW:0]                    div_q;

   assign n_act = (entries_ff == '0) ? tii_pkg::CNT_W'(1) :
                  (entries_ff > tii_pkg::CNT_W'(tii_pkg::TABLE_DEPTH)) ?
                  tii_pkg::CNT_W'(tii_pkg::TABLE_DEPTH) : entries_ff;
   assign last_idx = IW'(n_act - 1'b1);

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign q_ip   = req_query_position[tii_pkg::QPOS_W-1:FW];
   assign q_f    = req_query_position[FW-1:0];
   assign q_tiny = ({1'b0, q_f} < (FW+1)'(tii_pkg::TINY_LIM));
   assign q_end  = (q_ip > last_idx) || (q_ip == last_idx && !q_tiny);

   assign sum = (VW+FW+3)'(pa_ff) + (VW+FW+3)'(pb_ff);
   assign rnd = (sum + (VW+FW+3)'(1 << (FW-1))) >>> FW;

   assign den     = (VW+1)'(up_v_ff) - (VW+1)'(lo_v_ff);
   assign num_raw = (VW+1)'(x_ff) - (VW+1)'(lo_v_ff);
   assign num_clamp = num_raw[VW] ? '0 : (num_raw > den) ? den : num_raw;
   assign mid_sum = {1'b0, low_ff} + {1'b0, up_ff};
   assign div_start = (state_ff == S_I_D) && (den > 0);

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= tii_pkg::CNT_W'(tii_pkg::TABLE_DEPTH);
      end else if (csr_valid && csr_ready) begin
         entries_ff <= csr_entries_in_use;
      end
   end

   // table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (req_xfer && req_mode == tii_pkg::MODE_WR) begin
         mem[req_entry_index] <= req_entry_value;
      end
      rdata_ff <= mem[raddr_ff];
   end

   tii_frac_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_clamp),
      .den   (den),
      .done  (div_done),
      .quot  (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               res_val_ff <= '0;
               res_pos_ff <= '0;
               res_st_ff  <= (req_xfer && req_mode == tii_pkg::MODE_FWD && q_end) ?
                             tii_pkg::ST_END : tii_pkg::ST_OK;
               if (req_xfer) begin
                  case (req_mode)
                     tii_pkg::MODE_FWD: begin
                        raddr_ff  <= q_end ? last_idx : q_ip;
                        ip1_ff    <= q_ip + 1'b1;
                        single_ff <= q_end || q_tiny;
                        frac_ff   <= q_f;
                        state_ff  <= S_F_A;
                     end
                     tii_pkg::MODE_INV: begin
                        x_ff     <= req_probe_value;
                        raddr_ff <= '0;
                        state_ff <= S_I_A;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_F_A: begin
               raddr_ff <= ip1_ff;
               state_ff <= S_F_B;
            end
            S_F_B: begin
               a_ff <= rdata_ff;
               if (single_ff) begin
                  res_val_ff <= rdata_ff;
                  state_ff   <= S_DONE;
               end else begin
                  state_ff <= S_F_C;
               end
            end
            S_F_C: begin
               pa_ff <= a_ff * $signed({2'b0, (FW+1)'(1 << FW) - (FW+1)'(frac_ff)});
               pb_ff <= rdata_ff * $signed({2'b0, frac_ff});
               state_ff <= S_F_D;
            end
            S_F_D: begin
               res_val_ff <= rnd[VW-1:0];
               state_ff   <= S_DONE;
            end
            S_I_A: begin
               raddr_ff <= last_idx;
               state_ff <= S_I_B;
            end
            S_I_B: begin
               lo_v_ff <= rdata_ff;
               if (rdata_ff > x_ff) begin
                  res_st_ff <= tii_pkg::ST_BELOW;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_I_C;
               end
            end
            S_I_C: begin
               up_v_ff <= rdata_ff;
               low_ff  <= '0;
               up_ff   <= last_idx;
               if (rdata_ff < x_ff) begin
                  res_pos_ff <= tii_pkg::FPOS_W'({last_idx, FW'(0)});
                  res_st_ff  <= tii_pkg::ST_END;
                  state_ff   <= S_DONE;
               end else if (last_idx == '0) begin
                  res_st_ff <= tii_pkg::ST_FLAT;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_I_S;
               end
            end
            S_I_S: begin
               if (up_ff - low_ff > IW'(1)) begin
                  raddr_ff <= mid_sum[IW:1];
                  mid_ff   <= mid_sum[IW:1];
                  state_ff <= S_I_W;
               end else begin
                  state_ff <= S_I_D;
               end
            end
            S_I_W: state_ff <= S_I_M;
            S_I_M: begin
               if (rdata_ff > x_ff) begin
                  up_ff   <= mid_ff;
                  up_v_ff <= rdata_ff;
               end else begin
                  low_ff  <= mid_ff;
                  lo_v_ff <= rdata_ff;
               end
               state_ff <= S_I_S;
            end
            S_I_D: begin
               if (den > 0) begin
                  state_ff <= S_I_V;
               end else begin
                  res_pos_ff <= tii_pkg::FPOS_W'({low_ff, FW'(0)});
                  res_st_ff  <= tii_pkg::ST_FLAT;
                  state_ff   <= S_DONE;
               end
            end
            S_I_V: begin
               if (div_done) begin
                  res_pos_ff <= tii_pkg::FPOS_W'({low_ff, FW'(0)})
                                + tii_pkg::FPOS_W'(div_q);
                  state_ff   <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_val_ff   <= res_val_ff;
                  rsp_pos_ff   <= res_pos_ff;
                  rsp_st_ff    <= res_st_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_interp_value   = rsp_val_ff;
   assign rsp_found_position = rsp_pos_ff;
   assign rsp_status         = rsp_st_ff;
endmodule

### sv/tii_frac_div.sv
`timescale 1ns / 1ps

// floor(num * 2^FRAC_W / den) for 0 <= num <= den, den > 0; one bit per cycle
module tii_frac_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tii_pkg::VAL_W:0]      num,
   input  logic [tii_pkg::VAL_W:0]      den,
   output logic                         done,
   output logic [tii_pkg::FRAC_W:0]     quot
);
   logic                              busy_ff;
   logic                              done_ff;
   logic [tii_pkg::VAL_W+1:0]         rem_ff;
   logic [tii_pkg::VAL_W:0]           den_ff;
   logic [tii_pkg::FRAC_W:0]          q_ff;
   logic [tii_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [tii_pkg::VAL_W+1:0]         rem2;
   logic [tii_pkg::VAL_W+1:0]         den_ext;

   assign rem2    = {rem_ff[tii_pkg::VAL_W:0], 1'b0};
   assign den_ext = {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            den_ff <= den;
            cnt_ff <= tii_pkg::DIV_CNT_W'(tii_pkg::FRAC_W);
            if (num == den) begin
               // full segment: quotient is exactly one
               q_ff    <= (tii_pkg::FRAC_W+1)'(1) << tii_pkg::FRAC_W;
               done_ff <= 1'b1;
            end else begin
               rem_ff  <= {1'b0, num};
               q_ff    <= '0;
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            if (rem2 >= den_ext) begin
               rem_ff <= rem2 - den_ext;
               q_ff   <= {q_ff[tii_pkg::FRAC_W-1:0], 1'b1};
            end else begin
               rem_ff <= rem2;
               q_ff   <= {q_ff[tii_pkg::FRAC_W-1:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == tii_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

### sv/tii_checker.sv
`timescale 1ns / 1ps
`include "table_interp_and_inverse_lookup_defines.svh"

module tii_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_mode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [31:0]        rsp_interp_value,
   input logic [24:0]        rsp_found_position,
   input logic [1:0]         rsp_status
);
   logic query_xfer;
   logic rsp_below;
   logic one_zero;

   assign query_xfer = req_valid && req_ready &&
                       (req_mode == tii_pkg::MODE_FWD || req_mode == tii_pkg::MODE_INV);
   assign rsp_below  = rsp_valid && rsp_status == tii_pkg::ST_BELOW;
   assign one_zero   = rsp_interp_value == '0 || rsp_found_position == '0;

   `TII_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TII_ASSERT_NOW(a_one_field, clock, reset, rsp_valid, one_zero)
   `TII_ASSERT_NOW(a_below_zero, clock, reset, rsp_below, rsp_found_position == '0)
   `TII_ASSERT_NEXT(a_query_busy, clock, reset, query_xfer, !req_ready)
   `TII_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)
endmodule

bind table_interp_and_inverse_lookup tii_checker u_tii_checker (.*);

### sim/tii_checker.sv
`timescale 1ns / 1ps

module tii_scoreboard (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_entry_index,
   input  logic signed [31:0] req_entry_value,
   input  logic [23:0]        req_query_position,
   input  logic signed [31:0] req_probe_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_interp_value,
   input  logic [24:0]        rsp_found_position,
   input  logic [1:0]         rsp_status,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [8:0]         csr_entries_in_use,
   output int                 errors,
   output int                 pending
);

   typedef struct {
      logic signed [31:0]  interp;
      logic [24:0]         found;
      tii_pkg::status_type status;
   } lookup_result_type;

   logic signed [31:0] value_mem [tii_pkg::TABLE_DEPTH];
   logic [8:0]         entry_count;
   lookup_result_type  lookup_q [$];

   function automatic int live_entries();
      int n;
      n = entry_count;
      if (n < 1) n = 1;
      if (n > tii_pkg::TABLE_DEPTH) n = tii_pkg::TABLE_DEPTH;
      return n;
   endfunction

   function automatic lookup_result_type interp_at(logic [23:0] pos);
      lookup_result_type r;
      int     n;
      longint ip, f, sum;
      bit     tiny;
      n = live_entries();
      ip = pos >> tii_pkg::FRAC_W;
      f = pos & ((1 << tii_pkg::FRAC_W) - 1);
      tiny = (f * 100000) < (1 << tii_pkg::FRAC_W);
      r.found = '0;
      r.status = tii_pkg::ST_OK;
      if (ip > n - 1 || (ip == n - 1 && !tiny)) begin
         r.interp = value_mem[n - 1];
         r.status = tii_pkg::ST_END;
      end else if (tiny) begin
         r.interp = value_mem[ip];
      end else begin
         sum = longint'(value_mem[ip]) * ((1 << tii_pkg::FRAC_W) - f)
             + longint'(value_mem[ip + 1]) * f;
         // round half up, then keep the low word
         sum = (sum + (1 << (tii_pkg::FRAC_W - 1))) >>> tii_pkg::FRAC_W;
         r.interp = sum[31:0];
      end
      return r;
   endfunction

   function automatic lookup_result_type position_of(logic signed [31:0] probe);
      lookup_result_type r;
      int     n, lo, hi, mid;
      longint x, den, num, pos;
      n = live_entries();
      lo = 0;
      hi = n - 1;
      x = probe;
      r.interp = '0;
      r.status = tii_pkg::ST_OK;
      pos = 0;
      if (longint'(value_mem[0]) > x) begin
         r.status = tii_pkg::ST_BELOW;
      end else if (longint'(value_mem[hi]) < x) begin
         pos = longint'(hi) << tii_pkg::FRAC_W;
         r.status = tii_pkg::ST_END;
      end else if (n == 1) begin
         r.status = tii_pkg::ST_FLAT;
      end else begin
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (longint'(value_mem[mid]) > x) hi = mid;
            else lo = mid;
         end
         den = longint'(value_mem[hi]) - longint'(value_mem[lo]);
         if (den <= 0) begin
            pos = longint'(lo) << tii_pkg::FRAC_W;
            r.status = tii_pkg::ST_FLAT;
         end else begin
            num = x - longint'(value_mem[lo]);
            if (num < 0) num = 0;
            if (num > den) num = den;
            pos = (longint'(lo) << tii_pkg::FRAC_W) + ((num << tii_pkg::FRAC_W) / den);
         end
      end
      if (pos > 33554431) pos = 33554431;
      r.found = pos[24:0];
      return r;
   endfunction

   task automatic report(string what, longint want, longint got);
      $display("%0t: %s differs, expected %0h got %0h", $realtime, what, want, got);
      errors++;
   endtask

   initial begin
      errors = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      lookup_result_type exp_r;
      if (reset) begin
         entry_count = 9'd256;
         lookup_q.delete();
      end else begin
         if (csr_valid && csr_ready) entry_count = csr_entries_in_use;
         if (req_valid && req_ready) begin
            case (tii_pkg::mode_type'(req_mode))
               tii_pkg::MODE_WR:  value_mem[req_entry_index] = req_entry_value;
               tii_pkg::MODE_FWD:
                  lookup_q.insert(lookup_q.size(), interp_at(req_query_position));
               tii_pkg::MODE_INV:
                  lookup_q.insert(lookup_q.size(), position_of(req_probe_value));
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (lookup_q.size() == 0) begin
               report("result transfer with nothing outstanding", 0, 1);
            end else begin
               exp_r = lookup_q.pop_front();
               if (rsp_interp_value !== exp_r.interp)
                  report("interp_value", exp_r.interp, rsp_interp_value);
               if (rsp_found_position !== exp_r.found)
                  report("found_position", exp_r.found, rsp_found_position);
               if (rsp_status !== exp_r.status)
                  report("status", exp_r.status, rsp_status);
            end
         end
      end
      pending = lookup_q.size();
   end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_mode;
   logic [7:0]         req_entry_index;
   logic signed [31:0] req_entry_value;
   logic [23:0]        req_query_position;
   logic signed [31:0] req_probe_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_interp_value;
   logic [24:0]        rsp_found_position;
   logic [1:0]         rsp_status;
   logic               csr_valid;
   logic               csr_ready;
   logic [8:0]         csr_entries_in_use;
   int                 errors;
   int                 pending;

   logic signed [31:0] shadow [tii_pkg::TABLE_DEPTH];
   int                 live_n;
   bit                 no_gaps;
   bit                 took;
   int                 stall;

   table_interp_and_inverse_lookup u_top (.*);

   tii_scoreboard u_chk (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   // receiver stalls, drawn once per result transfer
   always @(posedge clock) took <= rsp_valid && rsp_ready;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall = 0;
      end else begin
         if (took) stall = no_gaps ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // called at a falling edge, returns at a falling edge after the transfer
   task automatic send(tii_pkg::mode_type m, logic [7:0] idx, logic signed [31:0] val,
                       logic [23:0] pos, logic signed [31:0] probe);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode = m;
      req_entry_index = idx;
      req_entry_value = val;
      req_query_position = pos;
      req_probe_value = probe;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
      if (m == tii_pkg::MODE_WR) shadow[idx] = val;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      // a table write gives no result, so pending does not count it
      repeat (40) @(negedge clock);
   endtask

   task automatic set_count(logic [8:0] cnt);
      drain();
      csr_entries_in_use = cnt;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      live_n = (cnt == 0) ? 1 :
               (cnt > tii_pkg::TABLE_DEPTH ? tii_pkg::TABLE_DEPTH : cnt);
   endtask

   // shape 0 steep ascending, 1 gentle with flats, 2 arbitrary, 3 full range
   task automatic load_table(int shape, int upto);
      longint v, stp;
      v = (shape == 3) ? -64'sd2147483648 : -64'sd2147483648 + $urandom_range(0, 1 << 24);
      if (shape == 1) v = $signed($urandom) >>> 2;
      for (int i = 0; i < upto; i++) begin
         case (shape)
            0: stp = $urandom_range(1, (1 << 24) - 1);
            1: stp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1000);
            3: stp = 16777215;
            default: stp = 0;
         endcase
         if (shape == 2) v = $signed($urandom);
         send(tii_pkg::MODE_WR, i[7:0], v[31:0], 24'($urandom), 32'($urandom));
         v = v + stp;
      end
   endtask

   function automatic logic signed [31:0] pick_probe();
      longint p;
      int k;
      k = $urandom_range(0, live_n - 1);
      case ($urandom_range(0, 7))
         0: p = $signed($urandom);
         1: p = shadow[k] - 1;
         2: p = shadow[k] + 1;
         3: p = shadow[k];
         default: p = shadow[k] + longint'($urandom_range(0, 1 << 20));
      endcase
      if (p > 2147483647) p = 2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
   endfunction

   function automatic logic [23:0] pick_pos();
      int ip;
      logic [15:0] fr;
      ip = int'($urandom_range(0, live_n + 1));
      if (ip > 255) ip = 255;
      case ($urandom_range(0, 5))
         0: fr = 16'd0;
         1: fr = 16'd1;
         2: fr = 16'hFFFF;
         default: fr = 16'($urandom);
      endcase
      if ($urandom_range(0, 9) == 0) return 24'($urandom);
      return {ip[7:0], fr};
   endfunction

   task automatic random_items(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
         r = $urandom_range(0, 19);
         if (r < 9)
            send(tii_pkg::MODE_FWD, 8'($urandom), 32'($urandom), pick_pos(),
                 32'($urandom));
         else if (r < 18)
            send(tii_pkg::MODE_INV, 8'($urandom), 32'($urandom), 24'($urandom),
                 pick_probe());
         else if (r < 19)
            send(tii_pkg::MODE_NOP, 8'($urandom), 32'($urandom), 24'($urandom),
                 32'($urandom));
         else
            send(tii_pkg::MODE_WR, 8'($urandom), $signed(32'($urandom)), 24'($urandom),
                 32'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = tii_pkg::MODE_NOP;
      req_entry_index = '0;
      req_entry_value = '0;
      req_query_position = '0;
      req_probe_value = '0;
      csr_valid = 1'b0;
      csr_entries_in_use = 9'd256;
      no_gaps = 1'b0;
      live_n = tii_pkg::TABLE_DEPTH;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // every slot gets written before any lookup
      load_table(0, tii_pkg::TABLE_DEPTH);

      // directed corners
      send(tii_pkg::MODE_FWD, 8'd0, 32'sd0, 24'h000000, 32'sd0);
      send(tii_pkg::MODE_FWD, 8'd0, 32'sd0, 24'h000001, 32'sd0);
      send(tii_pkg::MODE_FWD, 8'd0, 32'sd0, 24'h00FFFF, 32'sd0);
      send(tii_pkg::MODE_FWD, 8'd0, 32'sd0, 24'hFE8000, 32'sd0);
      send(tii_pkg::MODE_FWD, 8'd0, 32'sd0, 24'hFF0000, 32'sd0);
      send(tii_pkg::MODE_FWD, 8'd0, 32'sd0, 24'hFF0001, 32'sd0);
      send(tii_pkg::MODE_FWD, 8'd0, 32'sd0, 24'hFFFFFF, 32'sd0);
      send(tii_pkg::MODE_INV, 8'd0, 32'sd0, 24'd0, 32'sh80000000);
      send(tii_pkg::MODE_INV, 8'd0, 32'sd0, 24'd0, 32'sh7FFFFFFF);
      send(tii_pkg::MODE_INV, 8'd0, 32'sd0, 24'd0, shadow[0]);
      send(tii_pkg::MODE_INV, 8'd0, 32'sd0, 24'd0, shadow[255]);
      send(tii_pkg::MODE_INV, 8'd0, 32'sd0, 24'd0, shadow[100] + 32'sd1);
      send(tii_pkg::MODE_NOP, 8'hFF, 32'sh7FFFFFFF, 24'hFFFFFF, 32'sh7FFFFFFF);

      // hold off until the block is empty
      while (pending != 0) @(negedge clock);

      set_count(9'd1);
      send(tii_pkg::MODE_FWD, 8'd0, 32'sd0, 24'h000000, 32'sd0);
      send(tii_pkg::MODE_FWD, 8'd0, 32'sd0, 24'h000100, 32'sd0);
      send(tii_pkg::MODE_INV, 8'd0, 32'sd0, 24'd0, shadow[0]);
      send(tii_pkg::MODE_INV, 8'd0, 32'sd0, 24'd0, shadow[0] - 32'sd1);
      send(tii_pkg::MODE_INV, 8'd0, 32'sd0, 24'd0, shadow[0] + 32'sd1);
      random_items(30);

      set_count(9'd0);
      random_items(20);

      set_count(9'd2);
      load_table(1, 2);
      random_items(40);

      set_count(9'd17);
      load_table(1, 17);
      random_items(60);

      set_count(9'd32);
      load_table(3, 32);
      random_items(50);

      set_count(9'd100);
      load_table(2, 100);
      random_items(60);

      set_count(9'd511);
      random_items(60);

      set_count(9'd255);
      random_items(40);

      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
